FILE: src/sstlc_pkg.sv
// Shared types, lamp patterns and helper functions for the four-street
// traffic light controller. No dependencies.
package sstlc_pkg;

    // Light phase codes shown on the light_phase output.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_FIRST_YL = 2'd1,
        PH_GREEN    = 2'd2,
        PH_CLOSE_YL = 2'd3
    } t_phase;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GREEN_START  = 2'd0;
    localparam logic [1:0] CFG_YELLOW_START = 2'd1;
    localparam logic [1:0] CFG_PHASE_END    = 2'd2;

    localparam logic [7:0] GREEN_START_RST  = 8'd60;
    localparam logic [7:0] YELLOW_START_RST = 8'd160;
    localparam logic [7:0] PHASE_END_RST    = 8'd220;

    // Lamp patterns per street, first (yellow) and green.
    localparam logic [3:0][7:0] FIRST_MAIN = {8'h24, 8'hA4, 8'h14, 8'h22};
    localparam logic [3:0][3:0] FIRST_AUX  = {4'h5, 4'h8, 4'h9, 4'h9};
    localparam logic [3:0][7:0] GREEN_MAIN = {8'h24, 8'h64, 8'h0C, 8'h21};
    localparam logic [3:0][3:0] GREEN_AUX  = {4'h3, 4'h8, 4'h9, 4'h9};

    typedef struct packed {
        logic [7:0] lamps_main;
        logic [3:0] lamps_aux;
        t_phase     phase;
    } t_pattern;

    typedef struct packed {
        logic       found;
        logic [1:0] street;
    } t_pick;

    // A threshold of zero is never reached.
    function automatic logic reached(input logic [7:0] thr, input logic [7:0] cnt);
        reached = (thr != 8'd0) && (thr <= cnt);
    endfunction

    function automatic t_pattern show_pattern(
        input logic [1:0] street,
        input logic [7:0] cnt,
        input logic [7:0] green_start,
        input logic [7:0] yellow_start
    );
        t_pattern p;
        logic     g;
        logic     y;
        g = reached(green_start, cnt);
        y = reached(yellow_start, cnt);
        if (g && !y) begin
            p.lamps_main = GREEN_MAIN[street];
            p.lamps_aux  = GREEN_AUX[street];
            p.phase      = PH_GREEN;
        end else begin
            p.lamps_main = FIRST_MAIN[street];
            p.lamps_aux  = FIRST_AUX[street];
            p.phase      = y ? PH_CLOSE_YL : PH_FIRST_YL;
        end
        return p;
    endfunction

    // Round-robin search for the first requesting street, starting at base.
    function automatic t_pick pick_street(input logic [3:0] sensors, input logic [1:0] base);
        t_pick      r;
        logic [1:0] s;
        r.found  = 1'b0;
        r.street = base;
        for (int k = 3; k >= 0; k--) begin
            s = base + 2'(k);
            if (sensors[s]) begin
                r.found  = 1'b1;
                r.street = s;
            end
        end
        return r;
    endfunction

endpackage

FILE: src/sensor_skip_traffic_light_controller_top.sv
// Top level of the four-street round-robin traffic light controller.
// Depends on sstlc_pkg for lamp patterns, phase codes and helper functions.
//
//  channel   signals                                   direction
//  input     i_in_valid / o_in_ready, i_sensors         tick words in
//  output    o_out_valid / i_out_ready, o_lamps_main,   result words out
//            o_lamps_aux, o_serving, o_light_phase
//  config    i_cfg_we, i_cfg_idx, i_cfg_data            register writes
//
// Each tick word is processed in the cycle it is accepted; its result is
// in the output register in the next cycle. One word per cycle is
// sustained unless the single output register is stalled. A new word is
// taken whenever the output register is empty or drained in the same
// cycle, so a stalled output holds back only the input. Synchronous reset
// clears the controller state and restores the default timing registers.
module sensor_skip_traffic_light_controller_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_sensors,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_lamps_main,
    output logic [3:0] o_lamps_aux,
    output logic [1:0] o_serving,
    output logic [1:0] o_light_phase,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_green_start;
    logic [7:0] r_yellow_start;
    logic [7:0] r_phase_end;

    logic [1:0] r_idx;
    logic       r_run;
    logic [7:0] r_cnt;
    logic [7:0] r_main;
    logic [3:0] r_aux;

    logic [1:0] n_idx;
    logic       n_run;
    logic [7:0] n_cnt;
    logic [7:0] n_main;
    logic [3:0] n_aux;
    sstlc_pkg::t_phase n_phase;

    logic              r_out_valid;
    logic [1:0]        r_out_serving;
    sstlc_pkg::t_phase r_out_phase;

    logic                accept;
    logic [7:0]          cnt_inc;
    sstlc_pkg::t_pattern pat_run;
    sstlc_pkg::t_pattern pat_start;
    sstlc_pkg::t_pick    pick;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_idx   = r_idx;
        n_run   = r_run;
        n_cnt   = r_cnt;
        n_main  = r_main;
        n_aux   = r_aux;
        n_phase = sstlc_pkg::PH_IDLE;
        cnt_inc = r_cnt + 8'd1;
        pat_run = sstlc_pkg::show_pattern(r_idx, cnt_inc, r_green_start, r_yellow_start);

        if (r_run) begin
            if (!i_sensors[r_idx]) begin
                // Request dropped: skip the street without counting.
                n_run = 1'b0;
                n_cnt = 8'd0;
                n_idx = r_idx + 2'd1;
            end else begin
                n_cnt   = cnt_inc;
                n_main  = pat_run.lamps_main;
                n_aux   = pat_run.lamps_aux;
                n_phase = pat_run.phase;
                if (cnt_inc >= r_phase_end) begin
                    n_run   = 1'b0;
                    n_cnt   = 8'd0;
                    n_idx   = r_idx + 2'd1;
                    n_phase = sstlc_pkg::PH_IDLE;
                end
            end
        end

        // A street may start in the same tick the previous phase ends.
        pick      = sstlc_pkg::pick_street(i_sensors, n_idx);
        pat_start = sstlc_pkg::show_pattern(pick.street, 8'd0, r_green_start, r_yellow_start);
        if (!n_run && pick.found) begin
            n_idx   = pick.street;
            n_run   = 1'b1;
            n_cnt   = 8'd0;
            n_main  = pat_start.lamps_main;
            n_aux   = pat_start.lamps_aux;
            n_phase = pat_start.phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_start  <= sstlc_pkg::GREEN_START_RST;
            r_yellow_start <= sstlc_pkg::YELLOW_START_RST;
            r_phase_end    <= sstlc_pkg::PHASE_END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sstlc_pkg::CFG_GREEN_START:  r_green_start  <= i_cfg_data;
                sstlc_pkg::CFG_YELLOW_START: r_yellow_start <= i_cfg_data;
                sstlc_pkg::CFG_PHASE_END:    r_phase_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_run       <= 1'b0;
            r_cnt       <= 8'd0;
            r_main      <= 8'd0;
            r_aux       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_idx  <= n_idx;
                r_run  <= n_run;
                r_cnt  <= n_cnt;
                r_main <= n_main;
                r_aux  <= n_aux;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the lamp words are the held lamp registers themselves.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_serving <= n_idx;
            r_out_phase   <= n_phase;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lamps_main  = r_main;
    assign o_lamps_aux   = r_aux;
    assign o_serving     = r_out_serving;
    assign o_light_phase = r_out_phase;

endmodule

FILE: bench/sensor_skip_traffic_light_controller_top_tb.sv
// Self-checking bench for the four-street traffic light controller: it predicts each result word
// from the accepted sensor words and compares it field by field with the block's output.
// Depends on sstlc_pkg and sensor_skip_traffic_light_controller_top.
module sensor_skip_traffic_light_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int         CYCLE_LIMIT    = 250000;

    typedef struct packed {
        logic [7:0]        lamps_main;
        logic [3:0]        lamps_aux;
        logic [1:0]        serving;
        sstlc_pkg::t_phase light_phase;
    } t_lamp_word;

    // Tracks the controller state and holds the result words still owed by the block.
    class t_lamp_book;
        t_lamp_word due_lamps[$];
        int         errors;
        logic [7:0] green_at;
        logic [7:0] yellow_at;
        logic [7:0] end_at;
        logic [1:0] street;
        logic       running;
        logic [7:0] ticks;
        logic [7:0] held_main;
        logic [3:0] held_aux;

        function new();
            errors    = 0;
            green_at  = 8'd60;
            yellow_at = 8'd160;
            end_at    = 8'd220;
            street    = 2'd0;
            running   = 1'b0;
            ticks     = 8'd0;
            held_main = 8'd0;
            held_aux  = 4'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                sstlc_pkg::CFG_GREEN_START:  green_at = value;
                sstlc_pkg::CFG_YELLOW_START: yellow_at = value;
                sstlc_pkg::CFG_PHASE_END:    end_at = value;
                default: ;
            endcase
        endfunction

        // Lamp drive bits {main, aux} of a street, first (yellow) or green pattern.
        function logic [11:0] street_lamps(bit green, logic [1:0] st);
            case ({green, st})
                3'b000:  return 12'h229;
                3'b001:  return 12'h149;
                3'b010:  return 12'hA48;
                3'b011:  return 12'h245;
                3'b100:  return 12'h219;
                3'b101:  return 12'h0C9;
                3'b110:  return 12'h648;
                default: return 12'h243;
            endcase
        endfunction

        // A threshold of zero never counts as reached.
        function sstlc_pkg::t_phase light_up();
            logic g;
            logic y;
            g = (green_at != 8'd0) && (green_at <= ticks);
            y = (yellow_at != 8'd0) && (yellow_at <= ticks);
            {held_main, held_aux} = street_lamps(g && !y, street);
            if (g && !y)
                return sstlc_pkg::PH_GREEN;
            return y ? sstlc_pkg::PH_CLOSE_YL : sstlc_pkg::PH_FIRST_YL;
        endfunction

        function void note_tick(logic [3:0] sensors);
            t_lamp_word        w;
            sstlc_pkg::t_phase ph;
            logic [1:0]        base;
            logic [1:0]        s;
            ph = sstlc_pkg::PH_IDLE;
            if (running) begin
                if (!sensors[street]) begin
                    running = 1'b0;
                    ticks   = 8'd0;
                    street  = street + 2'd1;
                end else begin
                    ticks = ticks + 8'd1;
                    ph    = light_up();
                    if (ticks >= end_at) begin
                        running = 1'b0;
                        ticks   = 8'd0;
                        street  = street + 2'd1;
                        ph      = sstlc_pkg::PH_IDLE;
                    end
                end
            end
            // A new street may start in the same tick that the previous phase ended.
            if (!running) begin
                base = street;
                for (int k = 0; k < 4; k++) begin
                    s = base + 2'(k);
                    if (!running && sensors[s]) begin
                        street  = s;
                        running = 1'b1;
                        ticks   = 8'd0;
                        ph      = light_up();
                    end
                end
            end
            w.lamps_main  = held_main;
            w.lamps_aux   = held_aux;
            w.serving     = street;
            w.light_phase = ph;
            due_lamps.push_back(w);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 40)
                $display("%0t ns mismatch: %s", $time, what);
        endtask

        task check_lamps(logic [7:0] m, logic [3:0] a, logic [1:0] sv, logic [1:0] ph);
            t_lamp_word want;
            if (due_lamps.size() == 0) begin
                report_mismatch("result word with no tick word pending");
                return;
            end
            want = due_lamps.pop_front();
            if (m !== want.lamps_main)
                report_mismatch($sformatf("lamps_main %h, expected %h", m, want.lamps_main));
            if (a !== want.lamps_aux)
                report_mismatch($sformatf("lamps_aux %h, expected %h", a, want.lamps_aux));
            if (sv !== want.serving)
                report_mismatch($sformatf("serving %0d, expected %0d", sv, want.serving));
            if (ph !== want.light_phase)
                report_mismatch($sformatf("light_phase %0d, expected %0d", ph,
                                          want.light_phase));
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [3:0] i_sensors = 4'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_lamps_main;
    logic [3:0] o_lamps_aux;
    logic [1:0] o_serving;
    logic [1:0] o_light_phase;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = 2'd0;
    logic [7:0] i_cfg_data = 8'd0;

    t_lamp_book book = new();
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         cycle_count = 0;

    sensor_skip_traffic_light_controller_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sensors     (i_sensors),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_lamps_main  (o_lamps_main),
        .o_lamps_aux   (o_lamps_aux),
        .o_serving     (o_serving),
        .o_light_phase (o_light_phase),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sensor_skip_traffic_light_controller_top_tb: FAIL");
            $finish;
        end
    end

    // Result side: check each accepted word, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_lamps(o_lamps_main, o_lamps_aux, o_serving, o_light_phase);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_tick(input logic [3:0] sensors);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sensors  <= sensors;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_tick(sensors);
    endtask

    // Hold the sender off until every owed result word has arrived.
    task automatic settle(input int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (book.due_lamps.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        book.set_reg(idx, value);
    endtask

    // The unused index is written too; the block must ignore it.
    task automatic program_timing(input logic [7:0] gs, input logic [7:0] ys,
                                  input logic [7:0] pe);
        settle(3);
        write_reg(sstlc_pkg::CFG_GREEN_START, gs);
        write_reg(sstlc_pkg::CFG_YELLOW_START, ys);
        write_reg(sstlc_pkg::CFG_PHASE_END, pe);
        write_reg(CFG_UNUSED_IDX, 8'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly steady sensor patterns long enough to run whole phases, with
    // single noise words and streets that drop out early.
    task automatic run_traffic(input logic [7:0] gs, input logic [7:0] ys, input logic [7:0] pe,
                               input int n, input int s_idle, input int r_idle);
        logic [3:0] demand;
        int         hold;
        int         cap;
        int         r;
        program_timing(gs, ys, pe);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        cap = 4 * int'(pe) + 8;
        if (cap > 300)
            cap = 300;
        demand = 4'd0;
        hold   = 0;
        for (int i = 0; i < n; i++) begin
            if (hold == 0) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    demand = 4'($urandom_range(1, 15));
                    hold   = $urandom_range(1, cap);
                end else if (r < 90) begin
                    demand = 4'($urandom_range(0, 15));
                    hold   = 1;
                end else begin
                    demand = demand & ~(4'b0001 << $urandom_range(0, 3));
                    hold   = $urandom_range(1, 4);
                end
            end
            hold--;
            send_tick(demand);
            if (i == n / 2)
                settle(0);
        end
    endtask

    initial begin
        logic [3:0] reset_words[10];
        reset_words = '{4'h0, 4'h0, 4'hF, 4'hF, 4'hE,
                        4'h0, 4'h8, 4'h8, 4'h1, 4'h4};
        send_idle_pct = 27;
        recv_idle_pct = 67;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: idle hold, wrap-around search, sensor drops.
        foreach (reset_words[j])
            send_tick(reset_words[j]);
        // Short phase run to its end and restarted on the same street.
        program_timing(8'd2, 8'd4, 8'd6);
        repeat (7) send_tick(4'h2);
        send_tick(4'h3);
        // Zero thresholds are never reached; every tick ends the phase.
        program_timing(8'd0, 8'd0, 8'd1);
        repeat (4) send_tick(4'hF);
        // A phase end of zero behaves as one.
        program_timing(8'hFF, 8'h00, 8'h00);
        send_tick(4'hF);
        send_tick(4'h5);
        send_tick(4'hA);

        run_traffic(8'd2, 8'd4, 8'd6, 170, 27, 67);
        run_traffic(8'd5, 8'd3, 8'd8, 170, 27, 67);
        run_traffic(8'd0, 8'd0, 8'd1, 150, 27, 67);
        run_traffic(8'd255, 8'd255, 8'd255, 300, 67, 27);
        run_traffic(8'd0, 8'd7, 8'd12, 170, 67, 27);
        run_traffic(8'd9, 8'd0, 8'd15, 170, 67, 27);
        run_traffic(8'd60, 8'd160, 8'd220, 260, 0, 0);
        run_traffic(8'd1, 8'd2, 8'd3, 170, 0, 0);

        settle(5);
        if (book.errors == 0)
            $display("sensor_skip_traffic_light_controller_top_tb: PASS");
        else
            $display("sensor_skip_traffic_light_controller_top_tb: FAIL");
        $finish;
    end
endmodule
